[sv/rps_pkg.sv]
// Package for the payload chunk splitter: types, constants and codes.
`default_nettype none

package rps_pkg;

    localparam int MAX_PAYLOAD_BYTES = 1024;

    localparam int LEN_W   = 10;
    localparam int TS_W    = 32;
    localparam int TICK_W  = 16;
    localparam int MULT_W  = 4;
    localparam int SHIFT_W = 2;
    localparam int MODE_W  = 2;
    localparam int CNT_W   = 7;
    localparam int LIMIT_W = 14;
    localparam int IDX_W   = 3;
    localparam int WDATA_W = 16;

    // Payload length cap: buffer size minus one, never above the field range.
    localparam logic [LEN_W-1:0] LEN_CAP =
        (MAX_PAYLOAD_BYTES - 1 > 1023) ? LEN_W'(1023) : LEN_W'(MAX_PAYLOAD_BYTES - 1);

    localparam logic [LIMIT_W-1:0] SOFT_BASE     = LIMIT_W'(80);
    localparam logic [LEN_W-1:0]   MIN_FRAME     = LEN_W'(16);
    localparam logic [MULT_W-1:0]  MULT_DEFAULT  = MULT_W'(1);
    localparam logic [CNT_W-1:0]   MAX_CHUNKS    = CNT_W'(64);
    localparam logic [CNT_W-1:0]   SOFT_MAX_FULL = CNT_W'(63);

    // Split modes; the unused code behaves as no split
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SOFT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HARD = 2'd2;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_SPLIT_MODE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_BYTES = 3'd1;
    localparam logic [IDX_W-1:0] REG_FRAME_TICKS = 3'd2;
    localparam logic [IDX_W-1:0] REG_SOFT_MULT   = 3'd3;
    localparam logic [IDX_W-1:0] REG_SOFT_SHIFT  = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0]  split_mode;
        logic [LEN_W-1:0]   frame_bytes;
        logic [TICK_W-1:0]  frame_ticks;
        logic [MULT_W-1:0]  soft_mult;
        logic [SHIFT_W-1:0] soft_shift;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HALVE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic halve;
        logic round;
        logic emit_full;
        logic emit_rest;
    } cmd_t;

    typedef struct packed {
        logic soft_mode;
        logic halve_need;
        logic full_avail;
        logic full_last;
        logic rest_ok;
        logic out_busy;
    } stat_t;

endpackage

`default_nettype wire

[sv/rps_ctrl.sv]
// Controller state machine of the payload chunk splitter.
`default_nettype none

module rps_ctrl
    import rps_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire stat_t st,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = st.soft_mode ? ST_HALVE : ST_EMIT;
                end
            end
            ST_HALVE: begin
                if (!st.halve_need) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!st.out_busy) begin
                    if (st.full_avail) begin
                        if (st.full_last) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_HALVE: begin
                cmd.halve = st.halve_need;
                cmd.round = !st.halve_need;
            end
            ST_EMIT: begin
                if (!st.out_busy) begin
                    cmd.emit_full = st.full_avail;
                    cmd.emit_rest = !st.full_avail && st.rest_ok;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/rps_dp.sv]
// Datapath of the payload chunk splitter: working registers and output register.
`default_nettype none

module rps_dp
    import rps_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cfg_t             cfg,
    input  wire cmd_t             cmd,
    output stat_t                 st,
    input  wire logic [LEN_W-1:0] s_payload_len,
    input  wire logic [TS_W-1:0]  s_timestamp,
    input  wire logic             s_starts_odd,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [LEN_W-1:0]      m_chunk_offset,
    output logic [LEN_W-1:0]      m_chunk_len,
    output logic [TS_W-1:0]       m_chunk_timestamp,
    output logic                  m_chunk_starts_odd,
    output logic                  m_last
);

    logic [LEN_W-1:0]   rem_reg;
    logic [LEN_W-1:0]   off_reg;
    logic [LEN_W-1:0]   size_reg;
    logic [TS_W-1:0]    ts_reg;
    logic               odd_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [LIMIT_W-1:0] limit_reg;

    logic               m_valid_reg;
    logic [LEN_W-1:0]   m_off_reg;
    logic [LEN_W-1:0]   m_len_reg;
    logic [TS_W-1:0]    m_ts_reg;
    logic               m_odd_reg;
    logic               m_last_reg;

    logic               mode_soft;
    logic               mode_hard;
    logic [LEN_W-1:0]   fb_eff;
    logic [MULT_W-1:0]  mult_eff;
    logic [LIMIT_W-1:0] limit_calc;
    logic [LEN_W-1:0]   len_sat;
    logic [LEN_W:0]     size_x2;
    logic               soft_full;
    logic               hard_full;
    logic [LEN_W-1:0]   chunk_sz;
    logic [TS_W-1:0]    ts_step;
    logic [LEN_W-1:0]   size_round;

    always_comb begin
        mode_soft  = (cfg.split_mode == MODE_SOFT);
        mode_hard  = (cfg.split_mode == MODE_HARD);
        fb_eff     = (cfg.frame_bytes < MIN_FRAME) ? MIN_FRAME : cfg.frame_bytes;
        mult_eff   = (cfg.soft_mult == '0) ? MULT_DEFAULT : cfg.soft_mult;
        limit_calc = (SOFT_BASE << cfg.soft_shift) * LIMIT_W'(mult_eff);
        len_sat    = (s_payload_len > LEN_CAP) ? LEN_CAP : s_payload_len;
        size_x2    = {size_reg, 1'b0};
        size_round = (size_reg > LEN_W'(1)) ? {size_reg[LEN_W-1:1], 1'b0} : size_reg;

        soft_full = (size_reg != '0) && ({1'b0, rem_reg} >= size_x2)
                    && (cnt_reg < SOFT_MAX_FULL);
        hard_full = (rem_reg >= fb_eff) && (cnt_reg < MAX_CHUNKS);

        chunk_sz = mode_hard ? fb_eff : size_reg;
        ts_step  = mode_hard ? TS_W'(cfg.frame_ticks) : TS_W'(size_x2 >> cfg.soft_shift);

        st.soft_mode  = mode_soft;
        st.halve_need = ({{(LIMIT_W-LEN_W){1'b0}}, size_reg} >= limit_reg);
        st.full_avail = mode_soft ? soft_full : (mode_hard ? hard_full : 1'b0);
        st.full_last  = mode_hard && (rem_reg == fb_eff);
        st.rest_ok    = mode_hard ? ((rem_reg != '0) && (cnt_reg < MAX_CHUNKS)) : 1'b1;
        st.out_busy   = m_valid_reg && !m_ready;
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rem_reg   <= len_sat;
            size_reg  <= len_sat;
            off_reg   <= '0;
            ts_reg    <= s_timestamp;
            odd_reg   <= s_starts_odd;
            cnt_reg   <= '0;
            limit_reg <= limit_calc;
        end else if (cmd.halve) begin
            size_reg <= size_reg >> 1;
        end else if (cmd.round) begin
            size_reg <= size_round;
        end else if (cmd.emit_full) begin
            rem_reg <= rem_reg - chunk_sz;
            off_reg <= off_reg + chunk_sz;
            ts_reg  <= ts_reg + ts_step;
            odd_reg <= odd_reg ^ chunk_sz[0];
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_full || cmd.emit_rest) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_full) begin
            m_off_reg  <= off_reg;
            m_len_reg  <= chunk_sz;
            m_ts_reg   <= ts_reg;
            m_odd_reg  <= odd_reg;
            m_last_reg <= st.full_last;
        end else if (cmd.emit_rest) begin
            m_off_reg  <= off_reg;
            m_len_reg  <= rem_reg;
            m_ts_reg   <= ts_reg;
            m_odd_reg  <= odd_reg;
            m_last_reg <= 1'b1;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_chunk_offset     = m_off_reg;
    assign m_chunk_len        = m_len_reg;
    assign m_chunk_timestamp  = m_ts_reg;
    assign m_chunk_starts_odd = m_odd_reg;
    assign m_last             = m_last_reg;

`ifndef SYNTHESIS
    a_one_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.emit_full && cmd.emit_rest))
        else $error("full and rest chunk issued together");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_full || cmd.emit_rest) |-> !(m_valid_reg && !m_ready))
        else $error("output register overwritten while stalled");

    a_span_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_full |=> ({1'b0, off_reg} + {1'b0, rem_reg})
                          == $past({1'b0, off_reg} + {1'b0, rem_reg}))
        else $error("offset plus remainder changed by a full chunk");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_full |-> (cnt_reg < MAX_CHUNKS))
        else $error("chunk count beyond limit");
`endif

endmodule

`default_nettype wire

[sv/rtp_payload_chunk_splitter.sv]
// Top level of the payload chunk splitter: register file, controller and datapath.
//
//  channel  direction  handshake          payload
//  s_       in         s_valid / s_ready  payload_len, timestamp, starts_odd
//  m_       out        m_valid / m_ready  chunk_offset, chunk_len, chunk_timestamp,
//                                         chunk_starts_odd, last
//  cfg_     in         cfg_wr_en          cfg_index, cfg_wdata (write only)
//
// One packet at a time. The block accepts a packet, then in soft mode halves the
// size until it is below the limit and rounds it down to even, then emits the
// chunks in turn; an empty packet in hard mode emits nothing.
// Chunks leave through a single output register; m_ready low holds the chunk
// sequencer. A new packet is accepted while the last chunk still waits in it.
// Reset (aresetn low, synchronous) returns to idle, empties the output register
// and loads the register defaults.
`default_nettype none

module rtp_payload_chunk_splitter
    import rps_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration writes
    input  wire logic               cfg_wr_en,
    input  wire logic [IDX_W-1:0]   cfg_index,
    input  wire logic [WDATA_W-1:0] cfg_wdata,
    // packet descriptor in
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [LEN_W-1:0]   s_payload_len,
    input  wire logic [TS_W-1:0]    s_timestamp,
    input  wire logic               s_starts_odd,
    // chunk descriptor out
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [LEN_W-1:0]        m_chunk_offset,
    output logic [LEN_W-1:0]        m_chunk_len,
    output logic [TS_W-1:0]         m_chunk_timestamp,
    output logic                    m_chunk_starts_odd,
    output logic                    m_last
);

    cfg_t  cfg_reg;
    cmd_t  cmd;
    stat_t st;

    // Register file; writes to unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.split_mode  <= MODE_NONE;
            cfg_reg.frame_bytes <= MIN_FRAME;
            cfg_reg.frame_ticks <= '0;
            cfg_reg.soft_mult   <= MULT_DEFAULT;
            cfg_reg.soft_shift  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SPLIT_MODE:  cfg_reg.split_mode  <= cfg_wdata[MODE_W-1:0];
                REG_FRAME_BYTES: cfg_reg.frame_bytes <= cfg_wdata[LEN_W-1:0];
                REG_FRAME_TICKS: cfg_reg.frame_ticks <= cfg_wdata[TICK_W-1:0];
                REG_SOFT_MULT:   cfg_reg.soft_mult   <= cfg_wdata[MULT_W-1:0];
                REG_SOFT_SHIFT:  cfg_reg.soft_shift  <= cfg_wdata[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer: accept, halve/round the soft size, then one chunk per transfer slot
    rps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // Offset, remainder, timestamp and parity tracking plus output register
    rps_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg                (cfg_reg),
        .cmd                (cmd),
        .st                 (st),
        .s_payload_len      (s_payload_len),
        .s_timestamp        (s_timestamp),
        .s_starts_odd       (s_starts_odd),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_chunk_offset     (m_chunk_offset),
        .m_chunk_len        (m_chunk_len),
        .m_chunk_timestamp  (m_chunk_timestamp),
        .m_chunk_starts_odd (m_chunk_starts_odd),
        .m_last             (m_last)
    );

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the payload chunk splitter.
`timescale 1ns / 100ps

module tb;
    import rps_pkg::*;

    // Selector three is not named in the package; it behaves as no split
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 400;    // long receiver hold-off
    localparam int DRAIN_PAD   = 8;      // covers an empty hard packet still in flight
    localparam int REPORT_CAP  = 64;     // stop printing after this many failures
    localparam int RAND_PHASES = 8;
    localparam int RAND_ITEMS  = 30;     // per random phase

    typedef struct packed {
        logic [LEN_W-1:0] offset;
        logic [LEN_W-1:0] len;
        logic [TS_W-1:0]  ts;
        logic             odd;
        logic             last;
    } chunk_t;

    // Keeps a shadow of the registers, cuts each accepted packet into the chunks
    // it must produce and checks the chunks that come out against them in order.
    class chunk_tracker;
        cfg_t   cfg;
        chunk_t chunks_due[$];
        int     failures;

        function new();
            cfg.split_mode  = MODE_NONE;
            cfg.frame_bytes = MIN_FRAME;
            cfg.frame_ticks = '0;
            cfg.soft_mult   = MULT_DEFAULT;
            cfg.soft_shift  = '0;
            failures = 0;
        endfunction

        function int pending();
            return chunks_due.size();
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [WDATA_W-1:0] data);
            case (idx)
                REG_SPLIT_MODE:  cfg.split_mode  = data[MODE_W-1:0];
                REG_FRAME_BYTES: cfg.frame_bytes = data[LEN_W-1:0];
                REG_FRAME_TICKS: cfg.frame_ticks = data[TICK_W-1:0];
                REG_SOFT_MULT:   cfg.soft_mult   = data[MULT_W-1:0];
                REG_SOFT_SHIFT:  cfg.soft_shift  = data[SHIFT_W-1:0];
                default: ;
            endcase
        endfunction

        function void add_chunk(int offset, int len, logic [TS_W-1:0] ts, logic odd,
                                logic last);
            chunk_t c;
            c.offset = LEN_W'(offset);
            c.len    = LEN_W'(len);
            c.ts     = ts;
            c.odd    = odd;
            c.last   = last;
            chunks_due.push_back(c);
        endfunction

        function void note_packet(logic [LEN_W-1:0] len_in, logic [TS_W-1:0] ts_in,
                                  logic odd_in);
            int remaining, size, limit, mult, frame, offset, count;
            logic [TS_W-1:0] ts;
            logic odd;
            remaining = (len_in > LEN_CAP) ? int'(LEN_CAP) : int'(len_in);
            ts = ts_in;
            odd = odd_in;
            offset = 0;
            count = 0;
            if (cfg.split_mode == MODE_SOFT) begin
                mult  = (cfg.soft_mult == '0) ? int'(MULT_DEFAULT) : int'(cfg.soft_mult);
                limit = (int'(SOFT_BASE) << cfg.soft_shift) * mult;
                size  = remaining;
                while (size >= limit)
                    size = size >> 1;
                if (size > 1)
                    size = (size >> 1) * 2;
                if (size > 0) begin
                    while (remaining >= 2 * size && count < int'(SOFT_MAX_FULL)) begin
                        add_chunk(offset, size, ts, odd, 1'b0);
                        count++;
                        ts = ts + TS_W'((2 * size) >> cfg.soft_shift);
                        odd = odd ^ size[0];
                        offset += size;
                        remaining -= size;
                    end
                end
                add_chunk(offset, remaining, ts, odd, 1'b1);
            end else if (cfg.split_mode == MODE_HARD) begin
                frame = (cfg.frame_bytes < MIN_FRAME) ? int'(MIN_FRAME)
                                                      : int'(cfg.frame_bytes);
                while (remaining >= frame && count < int'(MAX_CHUNKS)) begin
                    remaining -= frame;
                    add_chunk(offset, frame, ts, odd, remaining == 0);
                    count++;
                    ts = ts + TS_W'(cfg.frame_ticks);
                    odd = odd ^ frame[0];
                    offset += frame;
                end
                if (remaining > 0 && count < int'(MAX_CHUNKS))
                    add_chunk(offset, remaining, ts, odd, 1'b1);
            end else begin
                add_chunk(0, remaining, ts, odd, 1'b1);
            end
        endfunction

        function void check_field(string field, logic [TS_W-1:0] want,
                                  logic [TS_W-1:0] got);
            if (want !== got) begin
                failures++;
                if (failures <= REPORT_CAP)
                    $error("%s: expected %0d, got %0d", field, want, got);
            end
        endfunction

        function void check_chunk(chunk_t got);
            chunk_t want;
            if (chunks_due.size() == 0) begin
                failures++;
                if (failures <= REPORT_CAP)
                    $error("unexpected chunk: offset %0d len %0d ts %0d", got.offset,
                           got.len, got.ts);
                return;
            end
            want = chunks_due.pop_front();
            check_field("chunk_offset", want.offset, got.offset);
            check_field("chunk_len", want.len, got.len);
            check_field("chunk_timestamp", want.ts, got.ts);
            check_field("chunk_starts_odd", want.odd, got.odd);
            check_field("last", want.last, got.last);
        endfunction
    endclass

    // Clock, reset and all block inputs start at known values
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic               cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]   cfg_index = REG_SPLIT_MODE;
    logic [WDATA_W-1:0] cfg_wdata = '0;

    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [LEN_W-1:0] s_payload_len = '0;
    logic [TS_W-1:0]  s_timestamp = '0;
    logic             s_starts_odd = 1'b0;

    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [LEN_W-1:0] m_chunk_offset;
    logic [LEN_W-1:0] m_chunk_len;
    logic [TS_W-1:0]  m_chunk_timestamp;
    logic             m_chunk_starts_odd;
    logic             m_last;

    chunk_tracker sb = new();

    // Sender burst state and the request for the long receiver hold-off
    int   burst_left = 0;
    logic hold_req   = 1'b0;

    // Receiver pattern state, owned by the receiver process
    int rx_hold_left    = 0;
    int rx_stretch_left = 0;
    int rx_stretch_kind = 0;
    bit rx_hold_done    = 1'b0;

    int unsigned cycle_count = 0;

    always #10 aclk = ~aclk;

    rtp_payload_chunk_splitter uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_payload_len      (s_payload_len),
        .s_timestamp        (s_timestamp),
        .s_starts_odd       (s_starts_odd),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_chunk_offset     (m_chunk_offset),
        .m_chunk_len        (m_chunk_len),
        .m_chunk_timestamp  (m_chunk_timestamp),
        .m_chunk_starts_odd (m_chunk_starts_odd),
        .m_last             (m_last)
    );

    // Watchdog: a hung block or a lost chunk ends the run here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: checks every chunk transfer, then picks m_ready for the next edge.
    // Stretches of always-ready, light stalls and heavy stalls alternate; one long
    // hold-off, once requested, keeps m_ready low so the block backs up into s_ready.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_chunk('{m_chunk_offset, m_chunk_len, m_chunk_timestamp,
                             m_chunk_starts_odd, m_last});
        if (hold_req && !rx_hold_done) begin
            rx_hold_done = 1'b1;
            rx_hold_left = HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (rx_stretch_left == 0) begin
                rx_stretch_kind = $urandom_range(0, 2);
                rx_stretch_left = $urandom_range(8, 60);
            end
            rx_stretch_left--;
            case (rx_stretch_kind)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // One register write; random upper bits above the register width must be dropped
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WDATA_W-1:0] value,
                             input int bits);
        logic [WDATA_W-1:0] data;
        data = (WDATA_W'($urandom) << bits) | value;
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        sb.set_reg(idx, data);
        @(posedge aclk);
    endtask

    // Rewrites the whole register set; only called with the block idle
    task automatic program_regs(input logic [MODE_W-1:0] mode,
                                input logic [LEN_W-1:0] frame_bytes,
                                input logic [TICK_W-1:0] frame_ticks,
                                input logic [MULT_W-1:0] mult,
                                input logic [SHIFT_W-1:0] shift);
        write_reg(REG_SPLIT_MODE, WDATA_W'(mode), MODE_W);
        write_reg(REG_FRAME_BYTES, WDATA_W'(frame_bytes), LEN_W);
        write_reg(REG_FRAME_TICKS, WDATA_W'(frame_ticks), TICK_W);
        write_reg(REG_SOFT_MULT, WDATA_W'(mult), MULT_W);
        write_reg(REG_SOFT_SHIFT, WDATA_W'(shift), SHIFT_W);
        cfg_wr_en <= 1'b0;
    endtask

    // Offers one packet descriptor and returns at the edge of its transfer.
    // Bursts of random length with random gaps (sometimes none) between them.
    task automatic send_packet(input logic [LEN_W-1:0] len, input logic [TS_W-1:0] ts,
                               input logic odd);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_payload_len <= len;
        s_timestamp   <= ts;
        s_starts_odd  <= odd;
        do @(posedge aclk); while (!s_ready);
        sb.note_packet(len, ts, odd);
    endtask

    // Sender pauses until every expected chunk is out and the block has settled
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_PAD) @(posedge aclk);
    endtask

    initial begin
        logic [MODE_W-1:0] mode;
        int                frame;
        logic [LEN_W-1:0]  len;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Register defaults after reset: no split
        send_packet(10'd0, 32'h0000_0000, 1'b0);
        send_packet(10'd1023, 32'hFFFF_FFFF, 1'b1);
        send_packet(10'd512, 32'h8000_0000, 1'b0);

        // Selector three acts as no split; frame below minimum, multiplier zero
        wait_idle();
        program_regs(MODE_UNUSED, 10'd5, 16'd0, 4'd0, 2'd0);
        send_packet(10'd1023, 32'h1234_5678, 1'b1);
        send_packet(10'd0, 32'hFFFF_FFFF, 1'b0);

        // Soft split at the smallest threshold; empty packet gives one empty chunk
        wait_idle();
        program_regs(MODE_SOFT, MIN_FRAME, 16'd0, 4'd0, 2'd0);
        send_packet(10'd0, 32'h0000_0001, 1'b1);
        send_packet(10'd1, 32'h0000_0002, 1'b0);
        send_packet(10'd2, 32'h0000_0003, 1'b1);
        send_packet(10'd3, 32'h0000_0004, 1'b0);
        send_packet(10'd1023, 32'hFFFF_FFF0, 1'b1);
        send_packet(10'd80, 32'h0000_0000, 1'b0);
        send_packet(10'd79, 32'h7FFF_FFFF, 1'b1);

        // Soft split at the largest threshold and shift
        wait_idle();
        program_regs(MODE_SOFT, 10'd1023, 16'hFFFF, 4'd15, 2'd3);
        send_packet(10'd1023, 32'hFFFF_FF00, 1'b1);
        send_packet(10'd0, 32'h0000_0007, 1'b1);

        // Hard split, minimum frame: most chunks, empty packet, exact multiple
        wait_idle();
        program_regs(MODE_HARD, 10'd5, 16'hFFFF, 4'd1, 2'd0);
        send_packet(10'd1023, 32'hFFFF_FFFF, 1'b1);
        send_packet(10'd0, 32'h0000_0003, 1'b0);
        send_packet(10'd32, 32'h0000_0009, 1'b1);
        send_packet(10'd15, 32'h0000_0004, 1'b0);

        // Hard split, largest frame
        wait_idle();
        program_regs(MODE_HARD, 10'd1023, 16'd0, 4'd15, 2'd3);
        send_packet(10'd1023, 32'hAAAA_5555, 1'b0);
        send_packet(10'd1022, 32'h5555_AAAA, 1'b1);
        send_packet(10'd0, 32'h0000_0000, 1'b1);

        // Odd frame size flips the parity on every frame
        wait_idle();
        program_regs(MODE_HARD, 10'd17, 16'd1234, 4'd1, 2'd0);
        send_packet(10'd100, 32'hFFFF_FC00, 1'b1);

        // Random settings, random packets
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            case ($urandom_range(0, 9))
                0:          mode = MODE_NONE;
                1:          mode = MODE_UNUSED;
                2, 3, 4, 5: mode = MODE_SOFT;
                default:    mode = MODE_HARD;
            endcase
            program_regs(mode,
                         $urandom_range(0, 1) ? LEN_W'($urandom_range(0, 63))
                                              : LEN_W'($urandom_range(64, 1023)),
                         TICK_W'($urandom), MULT_W'($urandom), SHIFT_W'($urandom));
            // Long receiver hold-off while the sender keeps offering packets
            if (ph == 2)
                hold_req <= 1'b1;
            frame = (sb.cfg.frame_bytes < MIN_FRAME) ? int'(MIN_FRAME)
                                                     : int'(sb.cfg.frame_bytes);
            for (int i = 0; i < RAND_ITEMS; i++) begin
                case ($urandom_range(0, 7))
                    0:       len = LEN_W'($urandom_range(0, 20));
                    1:       len = LEN_W'(1023 - $urandom_range(0, 20));
                    2:       len = LEN_W'(frame * $urandom_range(0, 1023 / frame));
                    default: len = LEN_W'($urandom_range(0, 1023));
                endcase
                send_packet(len, $urandom, 1'($urandom));
            end
        end

        wait_idle();
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
